// ===== src/kbg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the Korotkoff beat generator.
package kbg_pkg;

  // Default values of the top-level parameters
  localparam int DUTY_FULL_DEF     = 1023;
  localparam int PRESSURE_BITS_DEF = 13;
  localparam int TIME_BITS_DEF     = 32;

  // Fixed field widths
  localparam int BEAT_LEN_W = 20;
  localparam int MIN_DUTY_W = 10;
  localparam int DUTY_W     = 10;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = 1'd1;

  // Register reset values
  localparam logic [BEAT_LEN_W-1:0] BEAT_LEN_RST = 20'd30000;
  localparam logic [MIN_DUTY_W-1:0] MIN_DUTY_RST = 10'd51;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ===== src/kbg_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one pressure/timestamp update per transaction.
interface kbg_in_if #(
  parameter int PRESSURE_BITS = kbg_pkg::PRESSURE_BITS_DEF,
  parameter int TIME_BITS     = kbg_pkg::TIME_BITS_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic [TIME_BITS-1:0]     time_us;
  logic [PRESSURE_BITS-1:0] arterial_pressure;
  logic [PRESSURE_BITS-1:0] cuff_pressure;
  logic [PRESSURE_BITS-1:0] systolic_level;
  logic [PRESSURE_BITS-1:0] diastolic_level;
  logic                     deflating;

  modport source (
    output valid, time_us, arterial_pressure, cuff_pressure,
           systolic_level, diastolic_level, deflating,
    input  ready
  );

  modport sink (
    input  valid, time_us, arterial_pressure, cuff_pressure,
           systolic_level, diastolic_level, deflating,
    output ready
  );
endinterface

// ===== src/kbg_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: duty and beat status per transaction.
interface kbg_out_if ();
  logic                        valid;
  logic                        ready;
  logic [kbg_pkg::DUTY_W-1:0]  duty;
  logic                        beat_active;
  logic                        beat_started;

  modport source (
    output valid, duty, beat_active, beat_started,
    input  ready
  );

  modport sink (
    input  valid, duty, beat_active, beat_started,
    output ready
  );
endinterface

// ===== src/kbg_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts updates, detects beat onsets and forms the duty dividend.
module kbg_front #(
  parameter int DUTY_FULL     = kbg_pkg::DUTY_FULL_DEF,
  parameter int PRESSURE_BITS = kbg_pkg::PRESSURE_BITS_DEF,
  parameter int TIME_BITS     = kbg_pkg::TIME_BITS_DEF,
  parameter int DW            = $clog2(DUTY_FULL + 1),
  parameter int PRODW         = PRESSURE_BITS + DW,
  parameter int QW            = 1 + TIME_BITS + PRODW + PRESSURE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  kbg_in_if.sink        in_chan,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_data
);

  localparam int PW = PRESSURE_BITS;

  logic [PW-1:0]    last_art_r;
  logic [PW-1:0]    last_art_nxt;
  logic             start;
  logic [PW-1:0]    num;
  logic [PW-1:0]    den;
  logic [PRODW-1:0] prod;

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

  // Onset: arterial crosses above the cuff while deflating with the cuff inside the band
  assign start = in_chan.deflating
              && (in_chan.cuff_pressure < in_chan.systolic_level)
              && (in_chan.cuff_pressure > in_chan.diastolic_level)
              && (in_chan.arterial_pressure > in_chan.cuff_pressure)
              && (last_art_r <= in_chan.cuff_pressure);

  // Only meaningful when start is set; then num < den
  assign num  = in_chan.cuff_pressure - in_chan.diastolic_level;
  assign den  = in_chan.systolic_level - in_chan.diastolic_level;
  assign prod = PRODW'(num) * PRODW'(DUTY_FULL);

  assign q_data = {start, in_chan.time_us, prod, den};

  assign last_art_nxt = q_push ? in_chan.arterial_pressure : last_art_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_art_r <= '0;
    end else begin
      last_art_r <= last_art_nxt;
    end
  end

endmodule

// ===== src/kbg_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO that decouples the front end from the divider back end.
module kbg_queue #(
  parameter int W     = 8,
  parameter int DEPTH = kbg_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [PTRW-1:0] wr_ptr_r;
  logic [PTRW-1:0] wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r;
  logic [PTRW-1:0] rd_ptr_nxt;
  logic [CNTW-1:0] count_r;
  logic [CNTW-1:0] count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign valid   = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/kbg_back.sv =====
`timescale 1ns / 1ps
// Back end: serial duty divider, beat timer and registered result stage.
module kbg_back #(
  parameter int DUTY_FULL     = kbg_pkg::DUTY_FULL_DEF,
  parameter int PRESSURE_BITS = kbg_pkg::PRESSURE_BITS_DEF,
  parameter int TIME_BITS     = kbg_pkg::TIME_BITS_DEF,
  parameter int DW            = $clog2(DUTY_FULL + 1),
  parameter int PRODW         = PRESSURE_BITS + DW,
  parameter int QW            = 1 + TIME_BITS + PRODW + PRESSURE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  logic [QW-1:0]                  q_data,
  output logic                           q_pop,
  input  logic [kbg_pkg::BEAT_LEN_W-1:0] beat_len,
  input  logic [kbg_pkg::MIN_DUTY_W-1:0] min_duty,
  kbg_out_if.source                      out_chan
);

  localparam int PW   = PRESSURE_BITS;
  localparam int CNTW = $clog2(DW + 1);
  localparam int CW   = (DW > kbg_pkg::MIN_DUTY_W) ? DW : kbg_pkg::MIN_DUTY_W;
  localparam int EW   = (TIME_BITS > kbg_pkg::BEAT_LEN_W) ? TIME_BITS : kbg_pkg::BEAT_LEN_W;
  localparam logic [CW-1:0] FULL_C = CW'(DUTY_FULL);

  kbg_pkg::back_state_t state_r, state_nxt;

  // Unpacked queue head
  logic                 q_start;
  logic [TIME_BITS-1:0] q_now;
  logic [PRODW-1:0]     q_prod;
  logic [PW-1:0]        q_den;

  assign q_start = q_data[QW-1];
  assign q_now   = q_data[PRODW+PW +: TIME_BITS];
  assign q_prod  = q_data[PW +: PRODW];
  assign q_den   = q_data[PW-1:0];

  // Item in work
  logic                 start_r;
  logic [TIME_BITS-1:0] now_r;
  logic [PW-1:0]        den_r;
  logic [PW-1:0]        rem_r;
  logic [DW-1:0]        num_lo_r;
  logic [DW-1:0]        quo_r;
  logic [CNTW-1:0]      cnt_r;

  // Beat state
  logic                       sounding_r;
  logic [TIME_BITS-1:0]       stamp_r;
  logic [kbg_pkg::DUTY_W-1:0] held_r;

  // Result stage
  logic                       out_valid_r;
  logic [kbg_pkg::DUTY_W-1:0] out_duty_r;
  logic                       out_active_r;
  logic                       out_started_r;

  logic                 out_free;
  logic                 div_en;
  logic                 commit;
  logic [PW:0]          trial;
  logic                 qbit;
  logic [TIME_BITS-1:0] elapsed;
  logic                 ended;
  logic [CW-1:0]        quo_ext;
  logic [CW-1:0]        min_ext;
  logic [CW-1:0]        clamped;

  assign out_free = !out_valid_r || out_chan.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kbg_pkg::B_IDLE: begin
        if (q_valid) begin
          state_nxt = q_start ? kbg_pkg::B_DIV : kbg_pkg::B_DONE;
        end
      end
      kbg_pkg::B_DIV: begin
        if (cnt_r == CNTW'(1)) begin
          state_nxt = kbg_pkg::B_DONE;
        end
      end
      kbg_pkg::B_DONE: begin
        if (out_free) begin
          state_nxt = kbg_pkg::B_IDLE;
        end
      end
      default: state_nxt = kbg_pkg::B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop  = 1'b0;
    div_en = 1'b0;
    commit = 1'b0;
    unique case (state_r)
      kbg_pkg::B_IDLE: q_pop  = q_valid;
      kbg_pkg::B_DIV:  div_en = 1'b1;
      kbg_pkg::B_DONE: commit = out_free;
      default: ;
    endcase
  end

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_r, num_lo_r[DW-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  // Beat timeout with wrapping timestamps
  assign elapsed = now_r - stamp_r;
  assign ended   = sounding_r && (EW'(elapsed) > EW'(beat_len));

  assign quo_ext = CW'(quo_r);
  assign min_ext = CW'(min_duty);

  always_comb begin
    clamped = quo_ext;
    if (clamped < min_ext) begin
      clamped = min_ext;
    end
    if (clamped > FULL_C) begin
      clamped = FULL_C;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kbg_pkg::B_IDLE;
      sounding_r  <= 1'b0;
      stamp_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        if (start_r) begin
          sounding_r <= 1'b1;
          stamp_r    <= now_r;
          held_r     <= clamped[kbg_pkg::DUTY_W-1:0];
        end else if (ended) begin
          sounding_r <= 1'b0;
          held_r     <= '0;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      start_r  <= q_start;
      now_r    <= q_now;
      den_r    <= q_den;
      rem_r    <= q_prod[PRODW-1:DW];
      num_lo_r <= q_prod[DW-1:0];
      quo_r    <= '0;
      cnt_r    <= CNTW'(DW);
    end else if (div_en) begin
      rem_r    <= qbit ? PW'(trial - {1'b0, den_r}) : trial[PW-1:0];
      num_lo_r <= num_lo_r << 1;
      quo_r    <= {quo_r[DW-2:0], qbit};
      cnt_r    <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (start_r) begin
        out_duty_r    <= clamped[kbg_pkg::DUTY_W-1:0];
        out_active_r  <= 1'b1;
        out_started_r <= 1'b1;
      end else if (ended) begin
        out_duty_r    <= '0;
        out_active_r  <= 1'b0;
        out_started_r <= 1'b0;
      end else begin
        out_duty_r    <= sounding_r ? held_r : '0;
        out_active_r  <= sounding_r;
        out_started_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.duty         = out_duty_r;
  assign out_chan.beat_active  = out_active_r;
  assign out_chan.beat_started = out_started_r;

`ifndef SYNTHESIS
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kbg_pkg::B_DIV |-> cnt_r != '0)
    else $error("divider running with zero step count");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != kbg_pkg::B_IDLE)
    else $error("popped transaction not taken into work");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && sounding_r == out_active_r)
    else $error("result does not match beat state");

  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !sounding_r |-> held_r == '0)
    else $error("held duty nonzero while silent");
`endif

endmodule

// ===== src/korotkoff_beat_generator.sv =====
`timescale 1ns / 1ps
// Korotkoff beat generator: each update yields one result transaction with
// the PWM duty, whether a beat is sounding, and whether this update started
// one. An update that starts a beat passes the back-end states B_IDLE,
// B_DIV and B_DONE; in B_DIV the bit-serial divider computes
// (cuff - dia) * DUTY_FULL / (sys - dia) one quotient bit per cycle. Any
// other update goes from B_IDLE straight to B_DONE. A two-entry queue lets
// the input side keep accepting while the divider works or a result waits
// to be taken. Registers: index 0 is the beat length in microseconds
// (reset 30000), index 1 the minimum duty of a started beat (reset 51).
module korotkoff_beat_generator #(
  parameter int DUTY_FULL     = kbg_pkg::DUTY_FULL_DEF,
  parameter int PRESSURE_BITS = kbg_pkg::PRESSURE_BITS_DEF,
  parameter int TIME_BITS     = kbg_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kbg_in_if.sink                        in_chan,
  kbg_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [kbg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [kbg_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DW    = $clog2(DUTY_FULL + 1);
  localparam int PRODW = PRESSURE_BITS + DW;
  localparam int QW    = 1 + TIME_BITS + PRODW + PRESSURE_BITS;

  logic [kbg_pkg::BEAT_LEN_W-1:0] beat_len_r;
  logic [kbg_pkg::MIN_DUTY_W-1:0] min_duty_r;

  logic          q_push;
  logic [QW-1:0] q_wdata;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_len_r <= kbg_pkg::BEAT_LEN_RST;
      min_duty_r <= kbg_pkg::MIN_DUTY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        kbg_pkg::REG_BEAT_LEN: beat_len_r <= cfg_data[kbg_pkg::BEAT_LEN_W-1:0];
        kbg_pkg::REG_MIN_DUTY: min_duty_r <= cfg_data[kbg_pkg::MIN_DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  kbg_front #(
    .DUTY_FULL     (DUTY_FULL),
    .PRESSURE_BITS (PRESSURE_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  kbg_queue #(
    .W     (QW),
    .DEPTH (kbg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  kbg_back #(
    .DUTY_FULL     (DUTY_FULL),
    .PRESSURE_BITS (PRESSURE_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .beat_len (beat_len_r),
    .min_duty (min_duty_r),
    .out_chan (out_chan)
  );

endmodule
